// ===== design/lpr_pkg.sv =====
`timescale 1ns / 1ps

package lpr_pkg;

  // Page number width
  localparam int unsigned VpnW = 20;

  // Command codes
  typedef enum logic {
    CMD_TOUCH = 1'b0,
    CMD_EVICT = 1'b1
  } lpr_cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } lpr_status_e;

  // Data handed from one cell to the next older cell
  typedef struct packed {
    logic            hit_seen; // a more recent cell matched the touched page
    logic            valid;    // this position holds a page
    logic [VpnW-1:0] vpn;      // page held (or the touched page into cell 0)
    logic [VpnW-1:0] victim;   // least recently used page found so far
  } lpr_link_t;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic            touch_en; // apply a touch this cycle
    logic            evict_en; // apply an evict this cycle
    logic [VpnW-1:0] vpn;      // page to compare against
  } lpr_op_t;

endpackage

// ===== design/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// command   start / busy              cmd_i, vpn_i
// result    done_o (one-cycle pulse)  victim_vpn_o, status_o
//
// One transaction per cycle: busy stays low, a command accepted at one edge
// gives its result on the ports during the next cycle.
// The recency stack is a row of ENTRIES cells; the hit search and the victim
// search ripple through the row within that cycle.
// Reset clears every cell's valid bit, which leaves the store empty.
// The receiver cannot stall; every result is shown for exactly one cycle.

module lru_page_replacement
  import lpr_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            cmd_i,
  input  logic [VpnW-1:0] vpn_i,
  output logic            done_o,
  output logic [VpnW-1:0] victim_vpn_o,
  output logic [1:0]      status_o
);

  lpr_link_t link [ENTRIES+1];
  logic      valid_vec [1:ENTRIES];
  lpr_op_t   op;
  logic      accept;
  logic      is_evict;
  logic      hit;
  logic      full;
  logic      empty;

  logic            done_q;
  logic [VpnW-1:0] victim_q, victim_d;
  lpr_status_e     status_q, status_d;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_evict = (cmd_i == CMD_EVICT);

  // Row state seen at the ends of the chain
  assign hit   = link[ENTRIES].hit_seen;
  assign full  = link[ENTRIES].valid;
  assign empty = !link[1].valid;

  // Broadcast operation; a miss on a full store leaves the row untouched
  assign op.touch_en = accept && !is_evict && (hit || !full);
  assign op.evict_en = accept && is_evict;
  assign op.vpn      = vpn_i;

  // Head of the chain feeds the touched page into the most recent cell
  assign link[0].hit_seen = 1'b0;
  assign link[0].valid    = 1'b1;
  assign link[0].vpn      = vpn_i;
  assign link[0].victim   = '0;

  // Valid bits seen from the older side
  assign valid_vec[ENTRIES] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g > 0) begin : g_vld
      assign valid_vec[g] = link[g+1].valid;
    end
    lpr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .link_i      (link[g]),
      .next_valid_i(valid_vec[g+1]),
      .link_o      (link[g+1])
    );
  end

  // Result for the accepted command
  always_comb begin
    victim_d = '0;
    status_d = ST_OK;
    if (is_evict) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        victim_d = link[ENTRIES].victim;
      end
    end else if (!hit && full) begin
      status_d = ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      victim_q <= victim_d;
      status_q <= status_d;
    end
  end

  assign done_o       = done_q;
  assign victim_vpn_o = victim_q;
  assign status_o     = status_q;

endmodule

// ===== design/lpr_cell.sv =====
`timescale 1ns / 1ps

module lpr_cell
  import lpr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lpr_op_t   op_i,
  input  lpr_link_t link_i,       // from the next more recent cell
  input  logic      next_valid_i, // valid of the next older cell
  output lpr_link_t link_o        // to the next older cell
);

  logic            valid_q, valid_d;
  logic [VpnW-1:0] vpn_q, vpn_d;
  logic            match;
  logic            last;

  // Compare and position decode
  assign match = valid_q && (vpn_q == op_i.vpn);
  assign last  = valid_q && !next_valid_i;

  // Next state: a touch shifts every cell up to and including the hit
  always_comb begin
    valid_d = valid_q;
    vpn_d   = vpn_q;
    if (op_i.touch_en && !link_i.hit_seen) begin
      valid_d = link_i.valid;
      vpn_d   = link_i.vpn;
    end else if (op_i.evict_en && last) begin
      valid_d = 1'b0;
    end
  end

  // Hand-off to the older neighbor
  assign link_o.hit_seen = link_i.hit_seen | match;
  assign link_o.valid    = valid_q;
  assign link_o.vpn      = vpn_q;
  assign link_o.victim   = last ? vpn_q : link_i.victim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Page storage, no reset needed
  always_ff @(posedge clk_i) begin
    vpn_q <= vpn_d;
  end

endmodule

// ===== design/lpr_checker.sv =====
`timescale 1ns / 1ps

module lpr_checker
  import lpr_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            cmd_i,
  input logic            done_o,
  input logic [VpnW-1:0] victim_vpn_o,
  input logic [1:0]      status_o
);

  // Every accepted transaction gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("result missing after accepted command");

  // No result without an accepted command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without accepted command");

  // Failed results (any status other than OK) carry no victim
  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (victim_vpn_o == '0))
    else $error("victim nonzero on failed command");

  // Empty-store status only for evicts, full-store status only for touches
  a_status_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni) && status_o == ST_EMPTY) |-> ($past(cmd_i) == CMD_EVICT))
    else $error("empty status on a touch");

  a_full_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni) && (status_o == ST_FULL || status_o == 2'd3))
      |-> ($past(cmd_i) == CMD_TOUCH && status_o == ST_FULL))
    else $error("bad full status");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .done_o      (done_o),
  .victim_vpn_o(victim_vpn_o),
  .status_o    (status_o)
);
